// ----- rtl/core/mpd_pkg.sv -----
// Shared types and constants for the minimum partition difference block.
// Holds the transaction structs and the controller/datapath command and status
// structs. No dependencies.
package mpd_pkg;

  // Fixed field widths of the transactions
  localparam int VALUE_W = 8;
  localparam int DIFF_W  = 12;

  // Defaults for the top-level parameters
  localparam int MAX_SUM_DEF   = 4095;
  localparam int VALUE_MAX_DEF = 255;
  localparam int WORD_BITS_DEF = 64;

  // Input transaction
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               last;
  } item_t;

  // Result transaction
  typedef struct packed {
    logic [DIFF_W-1:0] difference;
    logic              overflow;
  } result_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;      // latch the item, update the running total
    logic prime;       // load the word counter, read the first source word
    logic upd_issue;   // read destination and lower source word at the counter
    logic cnt_load;    // load the word counter with the top word
    logic cnt_dec;     // step the word counter down
    logic scan_issue;  // read the word at the counter for the search
    logic scan_check;  // capture the best sum on a hit
    logic emit;        // register the result and raise the strobe
    logic clear;       // return the bitset and total to the empty set
  } mpd_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic skip;      // item leaves the bitset unchanged
    logic at_q;      // counter reached the lowest destination word
    logic last;      // latched item closes the set
    logic ovf;       // total has passed the sum limit
    logic hit;       // search word holds a sum not above half the total
    logic cnt_zero;  // counter is at word zero
  } mpd_stat_t;

endpackage

// ----- rtl/core/min_partition_difference.sv -----
// Minimum partition difference over a set streamed in one element at a time.
// An element updates the bitset word by word, from the top word down to its own
// word index, one word per cycle through the two-read-port bitset memory (64 words
// by default); a zero element leaves the bitset unchanged. The last element adds,
// unless the total overflowed, a top-down word search, then a result state, and the
// strobe the cycle after. Synchronous reset empties the set; the receiver cannot stall.
module min_partition_difference
  import mpd_pkg::*;
#(
  parameter int MAX_SUM   = MAX_SUM_DEF,
  parameter int VALUE_MAX = VALUE_MAX_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  item_t   item,
  output logic    done,
  output result_t result
);

  mpd_cmd_t  cmd;
  mpd_stat_t stat;

  // Sequence the work
  mpd_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Hold the bitset and compute the result
  mpd_datapath #(
    .MAX_SUM   (MAX_SUM),
    .VALUE_MAX (VALUE_MAX),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .stat   (stat),
    .done   (done),
    .result (result)
  );

  // A result transaction only follows work in progress
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without preceding work");

  // Strobe lasts one cycle
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for two cycles");

  // Overflowed sets carry no difference
  a_ovf_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.overflow) |-> (result.difference == '0))
    else $error("overflow result with nonzero difference");

  // Return to idle right after the result is registered
  a_emit_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> !busy)
    else $error("block still busy after result");

endmodule

// ----- rtl/core/mpd_ctrl.sv -----
// Controller state machine for the minimum partition difference block.
// Sequences the bitset update, the search and the result transaction.
// Depends on mpd_pkg.
module mpd_ctrl
  import mpd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  mpd_stat_t stat,
  output mpd_cmd_t  cmd,
  output logic      busy
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_PRIME  = 3'd2;
  localparam logic [2:0] S_UPD    = 3'd3;
  localparam logic [2:0] S_DRAIN  = 3'd4;
  localparam logic [2:0] S_WRAP   = 3'd5;
  localparam logic [2:0] S_SCAN   = 3'd6;
  localparam logic [2:0] S_EMIT   = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  // Advance the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  // Decode next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_next = stat.skip ? S_WRAP : S_PRIME;
      end
      S_PRIME: begin
        cmd.prime  = 1'b1;
        state_next = S_UPD;
      end
      S_UPD: begin
        cmd.upd_issue = 1'b1;
        if (stat.at_q) begin
          state_next = S_DRAIN;
        end else begin
          cmd.cnt_dec = 1'b1;
        end
      end
      S_DRAIN: begin
        // last write of the update lands here
        state_next = S_WRAP;
      end
      S_WRAP: begin
        if (!stat.last) begin
          state_next = S_IDLE;
        end else if (stat.ovf) begin
          state_next = S_EMIT;
        end else begin
          cmd.cnt_load = 1'b1;
          state_next   = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_issue = 1'b1;
        cmd.scan_check = 1'b1;
        cmd.cnt_dec    = !stat.cnt_zero;
        if (stat.hit) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd.emit   = 1'b1;
        cmd.clear  = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/mpd_datapath.sv -----
// Datapath for the minimum partition difference block: bitset memory with
// valid bits, running total, word shifter and the best-sum search.
// Depends on mpd_pkg; driven by mpd_ctrl.
module mpd_datapath
  import mpd_pkg::*;
#(
  parameter int MAX_SUM   = MAX_SUM_DEF,
  parameter int VALUE_MAX = VALUE_MAX_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  item_t     item,
  input  mpd_cmd_t  cmd,
  output mpd_stat_t stat,
  output logic      done,
  output result_t   result
);

  localparam int NUM_WORDS = (MAX_SUM + WORD_BITS) / WORD_BITS;
  localparam int WIDX      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int TOP       = NUM_WORDS - 1;
  localparam int SUM_W     = $clog2(MAX_SUM + 2);
  localparam int NW        = ((SUM_W > VALUE_W) ? SUM_W : VALUE_W) + 1;
  localparam int RW        = $clog2(WORD_BITS);
  localparam int NVAL      = 2 ** VALUE_W;
  localparam int QMAX      = (NVAL - 1) / WORD_BITS;
  localparam int QW        = (QMAX > 0) ? $clog2(QMAX + 1) : 1;
  localparam int CW        = ((QW > WIDX) ? QW : WIDX) + 1;
  localparam int DW        = ((SUM_W + 1) > DIFF_W) ? (SUM_W + 1) : DIFF_W;

  typedef logic [QW+RW-1:0] split_tab_t [NVAL];

  // Word index and bit offset of every value, built by counting
  function automatic split_tab_t build_split();
    split_tab_t tab;
    int         qq;
    int         rr;
    qq = 0;
    rr = 0;
    for (int i = 0; i < NVAL; i++) begin
      tab[i] = {QW'(qq), RW'(rr)};
      rr++;
      if (rr == WORD_BITS) begin
        rr = 0;
        qq++;
      end
    end
    return tab;
  endfunction

  // Bits of the top word that stand for sums within the limit
  function automatic logic [WORD_BITS-1:0] build_top_mask();
    logic [WORD_BITS-1:0] m;
    m = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      if (TOP * WORD_BITS + b <= MAX_SUM) begin
        m[b] = 1'b1;
      end
    end
    return m;
  endfunction

  localparam split_tab_t           SPLIT    = build_split();
  localparam logic [WORD_BITS-1:0] TOP_MASK = build_top_mask();
  localparam logic [WORD_BITS-1:0] WORD_ONE = {{(WORD_BITS-1){1'b0}}, 1'b1};

  // Latched item and set state
  logic [VALUE_W-1:0]   v_r;
  logic [QW-1:0]        q_r;
  logic [RW-1:0]        r_r;
  logic                 last_r;
  logic [SUM_W-1:0]     total;
  logic                 ovf_r;
  logic [WIDX-1:0]      cnt;

  // Bitset memory and its valid bits
  logic [WORD_BITS-1:0] mem [NUM_WORDS];
  logic [NUM_WORDS-1:0] vld;

  // Read stage
  logic [WORD_BITS-1:0] a_data;
  logic [WORD_BITS-1:0] b_data;
  logic                 a_vld;
  logic                 b_vld;
  logic [WIDX-1:0]      a_addr;
  logic [WIDX-1:0]      b_addr;
  logic                 b_zero;
  logic                 a_pend_upd;
  logic                 a_pend_scan;
  logic                 b_pend;
  logic [WORD_BITS-1:0] hold;
  logic [SUM_W-1:0]     best;

  // Combinational signals
  logic [VALUE_W-1:0]   v_sat;
  logic [NW-1:0]        sum_next;
  logic                 rd_a_en;
  logic                 rd_b_en;
  logic [WIDX-1:0]      b_addr_next;
  logic                 at_q;
  logic [WORD_BITS-1:0] a_eff;
  logic [WORD_BITS-1:0] b_eff;
  logic [WORD_BITS-1:0] lo_part;
  logic [RW:0]          lo_shamt;
  logic [WORD_BITS-1:0] new_word;
  logic [SUM_W-1:0]     half;
  logic [SUM_W-1:0]     base;
  logic [SUM_W:0]       lim;
  logic [WORD_BITS-1:0] masked;
  logic [RW-1:0]        pos;
  logic                 hit;
  logic [DW-1:0]        diff_full;

  // Saturate the element and form the new total
  assign v_sat = ((VALUE_MAX < NVAL - 1) && (item.value > VALUE_W'(VALUE_MAX)))
               ? VALUE_W'(VALUE_MAX) : item.value;
  assign sum_next = NW'(total) + NW'(v_sat);

  // Read addressing
  assign rd_a_en     = cmd.upd_issue | cmd.scan_issue;
  assign rd_b_en     = cmd.prime | cmd.upd_issue;
  assign at_q        = (CW'(cnt) == CW'(q_r));
  assign b_addr_next = cmd.prime
                     ? WIDX'(CW'(TOP) - CW'(q_r))
                     : WIDX'(CW'(cnt) - CW'(q_r) - CW'(1));

  // Status to the controller
  assign stat.skip     = (v_r == '0) || (CW'(q_r) > CW'(TOP));
  assign stat.at_q     = at_q;
  assign stat.last     = last_r;
  assign stat.ovf      = ovf_r;
  assign stat.hit      = hit;
  assign stat.cnt_zero = (cnt == '0);

  // Item, total and counter registers
  always_ff @(posedge clk) begin
    if (rst) begin
      total  <= '0;
      ovf_r  <= 1'b0;
      cnt    <= '0;
    end else begin
      if (cmd.accept) begin
        if (sum_next > NW'(MAX_SUM)) begin
          total <= SUM_W'(MAX_SUM + 1);
          ovf_r <= 1'b1;
        end else begin
          total <= sum_next[SUM_W-1:0];
        end
      end else if (cmd.clear) begin
        total <= '0;
        ovf_r <= 1'b0;
      end
      if (cmd.prime || cmd.cnt_load) begin
        cnt <= WIDX'(TOP);
      end else if (cmd.cnt_dec) begin
        cnt <= cnt - WIDX'(1);
      end
    end
  end

  // Latch the element split into word index and bit offset
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      v_r    <= v_sat;
      q_r    <= SPLIT[v_sat][QW+RW-1:RW];
      r_r    <= SPLIT[v_sat][RW-1:0];
      last_r <= item.last;
    end
  end

  // Memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (a_pend_upd) begin
      mem[a_addr] <= new_word;
    end
    if (rd_a_en) begin
      a_data <= mem[cnt];
    end
    if (rd_b_en) begin
      b_data <= mem[b_addr_next];
    end
  end

  // Valid bits and read-stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      vld         <= '0;
      a_pend_upd  <= 1'b0;
      a_pend_scan <= 1'b0;
      b_pend      <= 1'b0;
    end else begin
      if (cmd.clear) begin
        vld <= '0;
      end else if (a_pend_upd) begin
        vld[a_addr] <= 1'b1;
      end
      a_pend_upd  <= cmd.upd_issue;
      a_pend_scan <= cmd.scan_issue;
      b_pend      <= rd_b_en;
    end
  end

  // Read-stage payload
  always_ff @(posedge clk) begin
    if (rd_a_en) begin
      a_addr <= cnt;
      a_vld  <= vld[cnt];
    end
    if (rd_b_en) begin
      b_addr <= b_addr_next;
      b_vld  <= vld[b_addr_next];
      b_zero <= cmd.upd_issue && at_q;
    end
    if (b_pend) begin
      hold <= b_eff;
    end
  end

  // Words never written read as the empty set
  assign a_eff = a_vld ? a_data : ((a_addr == '0) ? WORD_ONE : '0);
  assign b_eff = b_zero ? '0 : (b_vld ? b_data : ((b_addr == '0) ? WORD_ONE : '0));

  // Shift the source pair up by the bit offset and merge into the destination
  assign lo_shamt = (RW+1)'(WORD_BITS) - {1'b0, r_r};
  assign lo_part  = (r_r == '0) ? '0 : (b_eff >> lo_shamt);
  always_comb begin
    new_word = a_eff | (hold << r_r) | lo_part;
    if (a_addr == WIDX'(TOP)) begin
      new_word = new_word & TOP_MASK;
    end
  end

  // Search: keep bits not above half the total, take the highest
  assign half = total >> 1;
  assign base = SUM_W'(32'(a_addr) * WORD_BITS);
  assign lim  = (SUM_W+1)'(half) - (SUM_W+1)'(base);
  always_comb begin
    masked = '0;
    pos    = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      masked[b] = a_eff[b] && !lim[SUM_W] && ((SUM_W+1)'(b) <= lim);
    end
    for (int b = 0; b < WORD_BITS; b++) begin
      if (masked[b]) begin
        pos = RW'(b);
      end
    end
  end
  assign hit = a_pend_scan && (masked != '0);

  // Capture the best reachable sum
  always_ff @(posedge clk) begin
    if (cmd.scan_check && hit) begin
      best <= base + SUM_W'(pos);
    end
  end

  // Register the result transaction
  assign diff_full = DW'(total) - DW'({best, 1'b0});
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (ovf_r) begin
        result.difference <= '0;
        result.overflow   <= 1'b1;
      end else begin
        result.difference <= diff_full[DIFF_W-1:0];
        result.overflow   <= 1'b0;
      end
    end
  end

endmodule
